@@ hdl/inverted_page_table_lru_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the inverted page table block
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef INVERTED_PAGE_TABLE_LRU_DEFINES_SVH
`define INVERTED_PAGE_TABLE_LRU_DEFINES_SVH

// Checked only while the block is out of reset.
`define IPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ipt_pkg.sv @@
// ----------------------------------------------------------------------------
// Inverted page table package
// Sizes, command and event codes, and the structs shared by the modules.
// ----------------------------------------------------------------------------
package ipt_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int PAGE_W     = 8;
    localparam int VPAGES     = 256;
    localparam int STAMP_W    = 32;
    localparam int CFG_W      = 5;

    // Command codes.
    localparam logic [2:0] MODE_READ   = 3'd0;
    localparam logic [2:0] MODE_WRITE  = 3'd1;
    localparam logic [2:0] MODE_MAP_RO = 3'd2;
    localparam logic [2:0] MODE_MAP_RW = 3'd3;
    localparam logic [2:0] MODE_UNMAP  = 3'd4;

    // Event codes.
    localparam logic [3:0] EV_UNMAP_NONE    = 4'd0;
    localparam logic [3:0] EV_UNMAP_FREED   = 4'd1;
    localparam logic [3:0] EV_UNMAP_NOFRAME = 4'd2;
    localparam logic [3:0] EV_MAP_RO        = 4'd3;
    localparam logic [3:0] EV_MAP_RW        = 4'd4;
    localparam logic [3:0] EV_RD_HIT        = 4'd5;
    localparam logic [3:0] EV_RD_LOAD       = 4'd6;
    localparam logic [3:0] EV_RD_EVICT      = 4'd7;
    localparam logic [3:0] EV_WR_HIT        = 4'd8;
    localparam logic [3:0] EV_WR_LOAD       = 4'd9;
    localparam logic [3:0] EV_WR_EVICT      = 4'd10;
    localparam logic [3:0] EV_RD_ILLEGAL    = 4'd11;
    localparam logic [3:0] EV_WR_ILLEGAL    = 4'd12;
    localparam logic [3:0] EV_NOP           = 4'd15;

    typedef struct packed {
        logic [2:0]        mode;
        logic [PAGE_W-1:0] page_num;
    } ipt_cmd_t;

    typedef struct packed {
        logic [3:0]         event_res;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  evicted_page;
        logic [STAMP_W-1:0] stamp;
    } ipt_result_t;

    // One frame table entry as seen on the read port.
    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] last_use;
    } ipt_frame_rec_t;

    // Frame table write port. The last-use stamp is always written.
    typedef struct packed {
        logic               en;
        logic [FRAME_W-1:0] idx;
        logic               set_valid;
        logic               valid_val;
        logic               set_page;
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
    } ipt_wr_t;

    // Outcome of one pass over the frame table.
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] hit_idx;
        logic               free_found;
        logic [FRAME_W-1:0] free_idx;
        logic [FRAME_W-1:0] lru_idx;
    } ipt_scan_t;

endpackage

@@ hdl/ipt_frame_store.sv @@
// ----------------------------------------------------------------------------
// Frame table store
// Page, valid flag and last-use stamp per physical frame; one read, one write.
// ----------------------------------------------------------------------------
module ipt_frame_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ipt_pkg::ipt_wr_t                   wr,
    input  logic [ipt_pkg::FRAME_W-1:0]        rd_idx,
    output ipt_pkg::ipt_frame_rec_t            rd_entry
);

    logic [ipt_pkg::MAX_FRAMES-1:0] valid_reg;
    logic [ipt_pkg::PAGE_W-1:0]     page_reg [ipt_pkg::MAX_FRAMES];
    logic [ipt_pkg::STAMP_W-1:0]    last_use_reg [ipt_pkg::MAX_FRAMES];

    // All frames come out of reset free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en && wr.set_valid)
        begin
            valid_reg[wr.idx] <= wr.valid_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            last_use_reg[wr.idx] <= wr.stamp;
            if (wr.set_page)
            begin
                page_reg[wr.idx] <= wr.page;
            end
        end
    end

    assign rd_entry.valid    = valid_reg[rd_idx];
    assign rd_entry.page     = page_reg[rd_idx];
    assign rd_entry.last_use = last_use_reg[rd_idx];

endmodule

@@ hdl/ipt_scan_unit.sv @@
// ----------------------------------------------------------------------------
// Frame table scan unit
// Looks at one entry per cycle while step is high and tracks first hit, first free and LRU frame.
// ----------------------------------------------------------------------------
module ipt_scan_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          step,
    input  logic [ipt_pkg::FRAME_W-1:0]   idx,
    input  ipt_pkg::ipt_frame_rec_t       entry,
    input  logic [ipt_pkg::PAGE_W-1:0]    vp,
    output ipt_pkg::ipt_scan_t            status
);

    logic                          hit_reg, hit_next;
    logic [ipt_pkg::FRAME_W-1:0]   hit_idx_reg, hit_idx_next;
    logic                          free_reg, free_next;
    logic [ipt_pkg::FRAME_W-1:0]   free_idx_reg, free_idx_next;
    logic [ipt_pkg::FRAME_W-1:0]   lru_idx_reg, lru_idx_next;
    logic [ipt_pkg::STAMP_W-1:0]   lru_stamp_reg, lru_stamp_next;
    logic                          page_eq;
    logic                          older;

    assign page_eq = entry.valid && (entry.page == vp);
    // Strictly older only, so the lowest index wins on equal stamps.
    assign older   = entry.last_use < lru_stamp_reg;

    always_comb
    begin
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        lru_idx_next   = lru_idx_reg;
        lru_stamp_next = lru_stamp_reg;
        if (clear)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (step)
        begin
            if (!hit_reg && page_eq)
            begin
                hit_next     = 1'b1;
                hit_idx_next = idx;
            end
            if (!free_reg && !entry.valid)
            begin
                free_next     = 1'b1;
                free_idx_next = idx;
            end
            if ((idx == '0) || older)
            begin
                lru_idx_next   = idx;
                lru_stamp_next = entry.last_use;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            hit_reg  <= hit_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        lru_idx_reg   <= lru_idx_next;
        lru_stamp_reg <= lru_stamp_next;
    end

    assign status.hit        = hit_reg;
    assign status.hit_idx    = hit_idx_reg;
    assign status.free_found = free_reg;
    assign status.free_idx   = free_idx_reg;
    assign status.lru_idx    = lru_idx_reg;

endmodule

@@ hdl/inverted_page_table_lru.sv @@
// ----------------------------------------------------------------------------
// Inverted page table with LRU frame replacement
// Map, illegal, unknown and unmap-of-unmapped commands set their registered
// result in CHECK; access and unmap of a mapped page go on through SCAN,
// one step per active frame, and set their registered result in DONE.
// One command at a time: busy stays high until the result strobe.
// Reset clears frame valid flags and the access clock and sets the frame
// count to 16; a pass over all 256 entries then clears the permission map, busy high.
// ----------------------------------------------------------------------------
module inverted_page_table_lru (
    input  logic                            clk,
    input  logic                            rst_n,
    // Command channel: a transfer happens when start is high and busy is low.
    input  logic                            start,
    output logic                            busy,
    input  ipt_pkg::ipt_cmd_t               cmd,
    // Result strobe: one cycle per result, the receiver cannot stall.
    output logic                            result_valid,
    output ipt_pkg::ipt_result_t            result,
    // Frame count register write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ipt_pkg::CFG_W-1:0]       cfg_data
);

    // After reset CLEAR zeroes one permission entry per cycle. For each
    // command the sequencer walks CHECK once; accesses and unmaps of mapped
    // pages then go through SCAN for one cycle per active frame through the
    // shared scan unit, then DONE applies at most one frame table write.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                          state_reg, state_next;
    ipt_pkg::ipt_cmd_t               cmd_reg, cmd_next;
    logic [ipt_pkg::STAMP_W-1:0]     stamp_reg, stamp_next;
    logic [ipt_pkg::STAMP_W-1:0]     clock_reg, clock_next;
    logic [ipt_pkg::CFG_W-1:0]       cfg_reg, cfg_next;
    logic [ipt_pkg::FRAME_W-1:0]     idx_reg, idx_next;
    logic [ipt_pkg::PAGE_W-1:0]      clr_idx_reg, clr_idx_next;
    ipt_pkg::ipt_result_t            res_reg, res_next;
    logic                            res_valid_reg, res_valid_next;

    // Permission map: one read and one write per cycle, registered read.
    logic                            read_ok_mem [ipt_pkg::VPAGES];
    logic                            write_ok_mem [ipt_pkg::VPAGES];
    logic                            rd_ok_reg;
    logic                            wr_ok_reg;
    logic [ipt_pkg::PAGE_W-1:0]      perm_rd_addr;
    logic [ipt_pkg::PAGE_W-1:0]      perm_wr_addr;
    logic                            perm_set_rd;
    logic                            perm_set_wr;
    logic                            perm_val;

    logic                            is_write;
    logic                            rd_ok;
    logic                            wr_ok;
    logic [ipt_pkg::FRAME_W-1:0]     last_idx;
    logic [ipt_pkg::FRAME_W-1:0]     target_idx;
    logic [ipt_pkg::FRAME_W-1:0]     rd_idx;
    logic                            scan_clear;
    logic                            scan_step;
    ipt_pkg::ipt_wr_t                wr;
    ipt_pkg::ipt_frame_rec_t         entry;
    ipt_pkg::ipt_scan_t              scan;

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // The permissions of the accepted page are read at the accepting edge,
    // so CHECK sees them in its own cycle.
    assign perm_rd_addr = cmd_next.page_num;

    assign is_write = (cmd_reg.mode == ipt_pkg::MODE_WRITE);
    assign rd_ok    = rd_ok_reg;
    assign wr_ok    = wr_ok_reg;

    // Index of the last active frame. A count of zero behaves as one frame and
    // counts above the table depth behave as the full table.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            last_idx = '0;
        end
        else if (cfg_reg > ipt_pkg::CFG_W'(ipt_pkg::MAX_FRAMES))
        begin
            last_idx = ipt_pkg::FRAME_W'(ipt_pkg::MAX_FRAMES - 1);
        end
        else
        begin
            last_idx = ipt_pkg::FRAME_W'(cfg_reg - ipt_pkg::CFG_W'(1));
        end
    end

    // A hit wins over a free frame, and a free frame wins over eviction.
    assign target_idx = scan.hit        ? scan.hit_idx  :
                        scan.free_found ? scan.free_idx : scan.lru_idx;
    assign rd_idx     = (state_reg == ST_DONE) ? target_idx : idx_reg;

    ipt_frame_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_idx   (rd_idx),
        .rd_entry (entry)
    );

    ipt_scan_unit u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (scan_clear),
        .step   (scan_step),
        .idx    (idx_reg),
        .entry  (entry),
        .vp     (cmd_reg.page_num),
        .status (scan)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        stamp_next     = stamp_reg;
        clock_next     = clock_reg;
        cfg_next       = cfg_reg;
        idx_next       = idx_reg;
        clr_idx_next   = clr_idx_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        scan_clear     = 1'b0;
        scan_step      = 1'b0;
        perm_wr_addr   = cmd_reg.page_num;
        perm_set_rd    = 1'b0;
        perm_set_wr    = 1'b0;
        perm_val       = 1'b0;
        wr             = '0;
        wr.page        = cmd_reg.page_num;
        wr.stamp       = stamp_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                perm_set_rd  = 1'b1;
                perm_set_wr  = 1'b1;
                perm_wr_addr = clr_idx_reg;
                clr_idx_next = clr_idx_reg + ipt_pkg::PAGE_W'(1);
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    cfg_next = cfg_data;
                end
                if (start)
                begin
                    cmd_next   = cmd;
                    stamp_next = clock_reg;
                    // The access clock stops at its maximum value.
                    if (clock_reg != '1)
                    begin
                        clock_next = clock_reg + ipt_pkg::STAMP_W'(1);
                    end
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                res_next.event_res    = ipt_pkg::EV_NOP;
                res_next.frame        = '0;
                res_next.evicted_page = '0;
                res_next.stamp        = stamp_reg;
                res_valid_next        = 1'b1;
                state_next            = ST_IDLE;
                case (cmd_reg.mode)
                    ipt_pkg::MODE_MAP_RO:
                    begin
                        perm_set_rd        = 1'b1;
                        perm_val           = 1'b1;
                        res_next.event_res = ipt_pkg::EV_MAP_RO;
                    end
                    ipt_pkg::MODE_MAP_RW:
                    begin
                        perm_set_rd        = 1'b1;
                        perm_set_wr        = 1'b1;
                        perm_val           = 1'b1;
                        res_next.event_res = ipt_pkg::EV_MAP_RW;
                    end
                    ipt_pkg::MODE_UNMAP:
                    begin
                        if (!rd_ok && !wr_ok)
                        begin
                            res_next.event_res = ipt_pkg::EV_UNMAP_NONE;
                        end
                        else
                        begin
                            res_valid_next = 1'b0;
                            scan_clear     = 1'b1;
                            idx_next       = '0;
                            state_next     = ST_SCAN;
                        end
                    end
                    ipt_pkg::MODE_READ, ipt_pkg::MODE_WRITE:
                    begin
                        if (is_write ? !wr_ok : !rd_ok)
                        begin
                            res_next.event_res = is_write ? ipt_pkg::EV_WR_ILLEGAL
                                                          : ipt_pkg::EV_RD_ILLEGAL;
                        end
                        else
                        begin
                            res_valid_next = 1'b0;
                            scan_clear     = 1'b1;
                            idx_next       = '0;
                            state_next     = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        res_next.event_res = ipt_pkg::EV_NOP;
                    end
                endcase
            end

            ST_SCAN:
            begin
                scan_step = 1'b1;
                idx_next  = idx_reg + ipt_pkg::FRAME_W'(1);
                if (idx_reg == last_idx)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                res_next.frame        = '0;
                res_next.evicted_page = '0;
                res_next.stamp        = stamp_reg;
                res_valid_next        = 1'b1;
                state_next            = ST_IDLE;
                wr.idx                = target_idx;
                if (cmd_reg.mode == ipt_pkg::MODE_UNMAP)
                begin
                    perm_set_rd = 1'b1;
                    perm_set_wr = 1'b1;
                    perm_val    = 1'b0;
                    if (scan.hit)
                    begin
                        // The freed frame keeps its page but takes this stamp.
                        wr.en              = 1'b1;
                        wr.set_valid       = 1'b1;
                        wr.valid_val       = 1'b0;
                        res_next.event_res = ipt_pkg::EV_UNMAP_FREED;
                        res_next.frame     = scan.hit_idx;
                    end
                    else
                    begin
                        res_next.event_res = ipt_pkg::EV_UNMAP_NOFRAME;
                    end
                end
                else
                begin
                    wr.en          = 1'b1;
                    res_next.frame = target_idx;
                    if (scan.hit)
                    begin
                        res_next.event_res = is_write ? ipt_pkg::EV_WR_HIT
                                                      : ipt_pkg::EV_RD_HIT;
                    end
                    else if (scan.free_found)
                    begin
                        wr.set_valid       = 1'b1;
                        wr.valid_val       = 1'b1;
                        wr.set_page        = 1'b1;
                        res_next.event_res = is_write ? ipt_pkg::EV_WR_LOAD
                                                      : ipt_pkg::EV_RD_LOAD;
                    end
                    else
                    begin
                        // The victim's old page is read before it is replaced.
                        wr.set_page           = 1'b1;
                        res_next.evicted_page = entry.page;
                        res_next.event_res    = is_write ? ipt_pkg::EV_WR_EVICT
                                                         : ipt_pkg::EV_RD_EVICT;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clock_reg     <= '0;
            cfg_reg       <= ipt_pkg::CFG_W'(ipt_pkg::MAX_FRAMES);
            clr_idx_reg   <= '0;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            cfg_reg       <= cfg_next;
            clr_idx_reg   <= clr_idx_next;
            res_valid_reg <= res_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        stamp_reg <= stamp_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (perm_set_rd)
        begin
            read_ok_mem[perm_wr_addr] <= perm_val;
        end
        if (perm_set_wr)
        begin
            write_ok_mem[perm_wr_addr] <= perm_val;
        end
        rd_ok_reg <= read_ok_mem[perm_rd_addr];
        wr_ok_reg <= write_ok_mem[perm_rd_addr];
    end

endmodule

@@ hdl/ipt_checker.sv @@
// ----------------------------------------------------------------------------
// Inverted page table port checker
// Watches the top level's ports and flags sequencing and result code slips.
// ----------------------------------------------------------------------------
`include "inverted_page_table_lru_defines.svh"

module ipt_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  result_valid,
    input  ipt_pkg::ipt_result_t  result
);

    logic plain_res;

    // A strobed result that is not an eviction.
    assign plain_res = result_valid &&
                       (result.event_res != ipt_pkg::EV_RD_EVICT) &&
                       (result.event_res != ipt_pkg::EV_WR_EVICT);

    // An accepted command keeps the block busy in the following cycle.
    `IPT_ASSERT(a_accept_busy, start && !busy |=> busy, "busy did not rise after accept")

    // Every result closes a command that was in progress the cycle before.
    `IPT_ASSERT(a_result_after_busy, result_valid |-> $past(busy), "result without a command")

    // Eviction events alone carry an evicted page.
    `IPT_ASSERT(a_evict_page, plain_res |-> result.evicted_page == '0, "stray evicted page")

    // No result leaves the block in the cycle after reset was asserted.
    `IPT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !result_valid, "result strobe after reset")

endmodule

bind inverted_page_table_lru ipt_checker u_ipt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverted page table LRU block testbench
// Drives map, unmap, access and spare commands through the start/busy port.
// Every accepted command runs through a local model of the permission map,
// the frame table and the access clock, and each strobed result is compared
// field by field with the oldest prediction. The frame count register is
// rewritten between phases, the out-of-range codes among the values.
// ----------------------------------------------------------------------------
module tb;

    // The command field is three bits wide, so three codes are left unused.
    // The block must answer them with the no-operation event.
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 184;
    // The limit lies well above the slowest legal gap between two transfers, a
    // sender gap plus an access, and leaves plenty of room for a clearing pass.
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 25;

    // One row of the directed script. When pinned is set, the result is the
    // one typed in the row; otherwise the local model supplies it.
    typedef struct packed {
        ipt_pkg::ipt_cmd_t    cmd;
        logic                 pinned;
        ipt_pkg::ipt_result_t res;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    ipt_pkg::ipt_cmd_t    cmd = '0;
    logic                 result_valid;
    ipt_pkg::ipt_result_t result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [ipt_pkg::CFG_W-1:0] cfg_data = '0;

    // Pinned expectation that travels with the command currently offered.
    logic                 pin_valid = 1'b0;
    ipt_pkg::ipt_result_t pin_res = '0;

    // Model state of the block.
    logic [ipt_pkg::PAGE_W-1:0]  frame_owner [ipt_pkg::MAX_FRAMES];
    logic                        frame_busy  [ipt_pkg::MAX_FRAMES];
    logic [ipt_pkg::STAMP_W-1:0] frame_touch [ipt_pkg::MAX_FRAMES];
    logic                        may_read    [ipt_pkg::VPAGES];
    logic                        may_write   [ipt_pkg::VPAGES];
    logic [ipt_pkg::STAMP_W-1:0] access_count;
    logic [ipt_pkg::CFG_W-1:0]   frame_limit;

    ipt_pkg::ipt_result_t due_results [$];
    int          fault_count = 0;
    int          stall_cycles = 0;
    bit          no_idle = 1'b0;

    logic [ipt_pkg::CFG_W-1:0] phase_limits [PHASES-1] =
        '{5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd2, 5'd16, 5'd8};

    inverted_page_table_lru dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the model state and returns the result the
    // block owes for it. The stamp is taken before the clock advances, and
    // the clock sticks once it reaches all ones.
    function automatic ipt_pkg::ipt_result_t run_page_cmd(input ipt_pkg::ipt_cmd_t c);
        ipt_pkg::ipt_result_t       r;
        int                         n;
        int                         victim;
        logic [ipt_pkg::PAGE_W-1:0] vp;
        logic                       wr;
        bit                         done;
        r      = '0;
        vp     = c.page_num;
        done   = 1'b0;
        victim = 0;
        r.stamp = access_count;
        // A count of zero still manages one frame; anything past the store
        // depth is clipped to the depth.
        if (frame_limit == 0)
            n = 1;
        else if (frame_limit > ipt_pkg::MAX_FRAMES)
            n = ipt_pkg::MAX_FRAMES;
        else
            n = int'(frame_limit);
        if (access_count != '1)
            access_count++;
        case (c.mode)
            ipt_pkg::MODE_UNMAP:
            begin
                if (!may_read[vp] && !may_write[vp])
                    r.event_res = ipt_pkg::EV_UNMAP_NONE;
                else
                begin
                    may_read[vp]  = 1'b0;
                    may_write[vp] = 1'b0;
                    r.event_res   = ipt_pkg::EV_UNMAP_NOFRAME;
                    for (int i = 0; i < n; i++)
                    begin
                        if (!done && frame_busy[i] && frame_owner[i] == vp)
                        begin
                            // The freed frame takes this command's stamp.
                            frame_busy[i]  = 1'b0;
                            frame_touch[i] = r.stamp;
                            r.event_res    = ipt_pkg::EV_UNMAP_FREED;
                            r.frame        = ipt_pkg::FRAME_W'(i);
                            done           = 1'b1;
                        end
                    end
                end
            end
            ipt_pkg::MODE_MAP_RO:
            begin
                may_read[vp] = 1'b1;
                r.event_res  = ipt_pkg::EV_MAP_RO;
            end
            ipt_pkg::MODE_MAP_RW:
            begin
                may_read[vp]  = 1'b1;
                may_write[vp] = 1'b1;
                r.event_res   = ipt_pkg::EV_MAP_RW;
            end
            ipt_pkg::MODE_READ, ipt_pkg::MODE_WRITE:
            begin
                wr = (c.mode == ipt_pkg::MODE_WRITE);
                if (wr ? !may_write[vp] : !may_read[vp])
                    r.event_res = wr ? ipt_pkg::EV_WR_ILLEGAL : ipt_pkg::EV_RD_ILLEGAL;
                else
                begin
                    // Every active frame is searched for a hit before any
                    // free frame is considered.
                    for (int i = 0; i < n; i++)
                    begin
                        if (!done && frame_busy[i] && frame_owner[i] == vp)
                        begin
                            frame_touch[i] = r.stamp;
                            r.event_res    = wr ? ipt_pkg::EV_WR_HIT : ipt_pkg::EV_RD_HIT;
                            r.frame        = ipt_pkg::FRAME_W'(i);
                            done           = 1'b1;
                        end
                    end
                    for (int i = 0; i < n; i++)
                    begin
                        if (!done && !frame_busy[i])
                        begin
                            frame_busy[i]  = 1'b1;
                            frame_owner[i] = vp;
                            frame_touch[i] = r.stamp;
                            r.event_res    = wr ? ipt_pkg::EV_WR_LOAD : ipt_pkg::EV_RD_LOAD;
                            r.frame        = ipt_pkg::FRAME_W'(i);
                            done           = 1'b1;
                        end
                    end
                    if (!done)
                    begin
                        // Oldest stamp loses; a strict compare keeps the
                        // lowest index on equal stamps.
                        for (int i = 1; i < n; i++)
                            if (frame_touch[i] < frame_touch[victim])
                                victim = i;
                        r.evicted_page      = frame_owner[victim];
                        frame_owner[victim] = vp;
                        frame_touch[victim] = r.stamp;
                        r.event_res         = wr ? ipt_pkg::EV_WR_EVICT
                                                 : ipt_pkg::EV_RD_EVICT;
                        r.frame             = ipt_pkg::FRAME_W'(victim);
                    end
                end
            end
            default:
                r.event_res = ipt_pkg::EV_NOP;
        endcase
        return r;
    endfunction

    function automatic script_row_t row(input logic [2:0] m,
                                        input logic [ipt_pkg::PAGE_W-1:0] p,
                                        input logic pin, input logic [3:0] ev,
                                        input logic [ipt_pkg::FRAME_W-1:0] fr,
                                        input int st);
        script_row_t s;
        s.cmd.mode         = m;
        s.cmd.page_num     = p;
        s.pinned           = pin;
        s.res.event_res    = ev;
        s.res.frame        = fr;
        s.res.evicted_page = '0;
        s.res.stamp        = ipt_pkg::STAMP_W'(st);
        return s;
    endfunction

    // Random command. Most pages come from a working set a little larger
    // than the active frame count, so that loads, hits and evictions all
    // happen; the rest are drawn from the whole page range.
    function automatic ipt_pkg::ipt_cmd_t pick_page_cmd(input int pool);
        ipt_pkg::ipt_cmd_t c;
        int                roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            c.mode = ipt_pkg::MODE_READ;
        else if (roll < 60)
            c.mode = ipt_pkg::MODE_WRITE;
        else if (roll < 72)
            c.mode = ipt_pkg::MODE_MAP_RO;
        else if (roll < 84)
            c.mode = ipt_pkg::MODE_MAP_RW;
        else if (roll < 94)
            c.mode = ipt_pkg::MODE_UNMAP;
        else
            c.mode = MODE_SPARE_5 + 3'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 85)
            c.page_num = ipt_pkg::PAGE_W'($urandom_range(0, pool - 1) * 37 + 3);
        else
            c.page_num = ipt_pkg::PAGE_W'($urandom_range(0, ipt_pkg::VPAGES - 1));
        return c;
    endfunction

    // Offers one command and returns at the edge where the transfer takes
    // place. Start stays high on return, so back-to-back commands never
    // lower and raise it within one time step.
    task automatic send_page_cmd(input ipt_pkg::ipt_cmd_t c, input logic pin,
                                 input ipt_pkg::ipt_result_t want);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 33)
        begin
            gap = $urandom_range(1, 24);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        pin_valid <= pin;
        pin_res   <= want;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // Waits until every outstanding result has been strobed. The first edge
    // is always taken so that a prediction pushed at the current edge is seen.
    task automatic drain_results();
        do @(posedge clk); while (due_results.size() != 0);
    endtask

    // The frame count is only rewritten while the block is idle. Every
    // command strobes exactly one result and busy holds until the strobe,
    // so an empty prediction queue means nothing is in flight.
    task automatic set_frame_limit(input logic [ipt_pkg::CFG_W-1:0] value);
        start <= 1'b0;
        drain_results();
        if ($urandom_range(0, 99) < 33)
            repeat ($urandom_range(1, 8)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // Checks, prediction and the stall watchdog all run at the rising edge,
    // reading the values that the block itself sampled at that edge.
    always @(posedge clk)
    begin
        ipt_pkg::ipt_result_t want;
        if (rst_n)
        begin
            // A result strobed at the same edge as a new transfer belongs to
            // the older command, so it is checked before the new prediction.
            if (result_valid)
            begin
                if (due_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: result with nothing outstanding: ev=%0d fr=%0d",
                                 $realtime, result.event_res, result.frame);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.event_res    !== want.event_res ||
                        result.frame        !== want.frame ||
                        result.evicted_page !== want.evicted_page ||
                        result.stamp        !== want.stamp)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display({"%0t: mismatch expected ev=%0d fr=%0d evp=%0d st=%0d",
                                      " got ev=%0d fr=%0d evp=%0d st=%0d"},
                                     $realtime, want.event_res, want.frame,
                                     want.evicted_page, want.stamp, result.event_res,
                                     result.frame, result.evicted_page, result.stamp);
                    end
                end
            end
            if (start && !busy)
            begin
                want = run_page_cmd(cmd);
                if (pin_valid)
                    want = pin_res;
                due_results.push_back(want);
            end
            if (cfg_valid && cfg_ready)
                frame_limit = cfg_data;
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        script_row_t script [21];
        int          lim;

        // Reset state of the model: no permissions, all frames free.
        for (int i = 0; i < ipt_pkg::MAX_FRAMES; i++)
        begin
            frame_owner[i] = '0;
            frame_busy[i]  = 1'b0;
            frame_touch[i] = '0;
        end
        for (int i = 0; i < ipt_pkg::VPAGES; i++)
        begin
            may_read[i]  = 1'b0;
            may_write[i] = 1'b0;
        end
        access_count = '0;
        frame_limit  = ipt_pkg::CFG_W'(ipt_pkg::MAX_FRAMES);

        // Straight after reset every item's stamp equals its position in
        // this script, which makes most results easy to type in.
        script = '{
            row(ipt_pkg::MODE_READ,   8'd0,   1'b1, ipt_pkg::EV_RD_ILLEGAL, '0, 0),
            row(ipt_pkg::MODE_WRITE,  8'd255, 1'b1, ipt_pkg::EV_WR_ILLEGAL, '0, 1),
            row(ipt_pkg::MODE_UNMAP,  8'd7,   1'b1, ipt_pkg::EV_UNMAP_NONE, '0, 2),
            row(MODE_SPARE_5,         8'd170, 1'b1, ipt_pkg::EV_NOP,        '0, 3),
            row(MODE_SPARE_7,         8'd85,  1'b1, ipt_pkg::EV_NOP,        '0, 4),
            row(ipt_pkg::MODE_MAP_RO, 8'd0,   1'b1, ipt_pkg::EV_MAP_RO,     '0, 5),
            // Read-only mapping must still refuse a write.
            row(ipt_pkg::MODE_WRITE,  8'd0,   1'b1, ipt_pkg::EV_WR_ILLEGAL, '0, 6),
            row(ipt_pkg::MODE_READ,   8'd0,   1'b1, ipt_pkg::EV_RD_LOAD,    '0, 7),
            row(ipt_pkg::MODE_READ,   8'd0,   1'b0, ipt_pkg::EV_NOP,        '0, 0),
            row(ipt_pkg::MODE_MAP_RW, 8'd255, 1'b1, ipt_pkg::EV_MAP_RW,     '0, 9),
            row(ipt_pkg::MODE_WRITE,  8'd255, 1'b0, ipt_pkg::EV_NOP,        '0, 0),
            // Remapping read-only keeps the write permission already held.
            row(ipt_pkg::MODE_MAP_RO, 8'd255, 1'b1, ipt_pkg::EV_MAP_RO,     '0, 11),
            row(ipt_pkg::MODE_WRITE,  8'd255, 1'b0, ipt_pkg::EV_NOP,        '0, 0),
            row(ipt_pkg::MODE_UNMAP,  8'd0,   1'b0, ipt_pkg::EV_NOP,        '0, 0),
            row(ipt_pkg::MODE_READ,   8'd0,   1'b1, ipt_pkg::EV_RD_ILLEGAL, '0, 14),
            row(ipt_pkg::MODE_MAP_RW, 8'd0,   1'b1, ipt_pkg::EV_MAP_RW,     '0, 15),
            row(ipt_pkg::MODE_READ,   8'd0,   1'b0, ipt_pkg::EV_NOP,        '0, 0),
            // A mapped page that never got a frame unmaps with no frame.
            row(ipt_pkg::MODE_MAP_RO, 8'd128, 1'b1, ipt_pkg::EV_MAP_RO,     '0, 17),
            row(ipt_pkg::MODE_UNMAP,  8'd128, 1'b0, ipt_pkg::EV_NOP,        '0, 0),
            row(MODE_SPARE_6,         8'd255, 1'b1, ipt_pkg::EV_NOP,        '0, 19),
            row(ipt_pkg::MODE_READ,   8'd128, 1'b1, ipt_pkg::EV_RD_ILLEGAL, '0, 20)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[k])
            send_page_cmd(script[k].cmd, script[k].pinned, script[k].res);

        // Random phases, each under its own frame count. One phase runs
        // with no sender gaps at all; the last uses a random count.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            lim = (ph == PHASES - 1) ? $urandom_range(0, 31) : phase_limits[ph];
            set_frame_limit(ipt_pkg::CFG_W'(lim));
            if (lim == 0)
                lim = 1;
            else if (lim > ipt_pkg::MAX_FRAMES)
                lim = ipt_pkg::MAX_FRAMES;
            no_idle = (ph == 3);
            repeat (PHASE_ITEMS)
                send_page_cmd(pick_page_cmd(lim + 4), 1'b0, '0);
        end

        start <= 1'b0;
        drain_results();
        // A stray late strobe would show up within one access latency.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
